### design/rdsf_pkg.sv
// ----------------------------------------------------------------------------
// rdsf_pkg
// shared constants, controller states and command/status words
// ----------------------------------------------------------------------------
package rdsf_pkg;

  localparam int unsigned MaxEdgesDef   = 64;
  localparam int unsigned VertexBitsDef = 8;
  localparam int unsigned WeightBitsDef = 16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEL_GO,
    ST_SEL_WAIT,
    ST_FIND_GO,
    ST_FIND_WAIT,
    ST_UPD,
    ST_MERGE_GO,
    ST_MERGE_WAIT,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_e;

  typedef enum logic [1:0] {
    SCAN_SEL,
    SCAN_FIND,
    SCAN_MERGE
  } scan_e;

  typedef struct packed {
    logic  load;
    logic  scan_start;
    scan_e scan_mode;
    logic  mark;
    logic  keep;
    logic  next_rank;
    logic  out_rd;
    logic  out_next;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic reject;
    logic merge;
    logic last_rank;
    logic out_last;
  } sts_t;

endpackage

### design/reverse_delete_spanning_forest_core.sv
// ----------------------------------------------------------------------------
// reverse_delete_spanning_forest_core
// minimum spanning forest over a loaded edge list
// ----------------------------------------------------------------------------
// Edges load one word per cycle until a word with last_edge_i; words beyond
// MAX_EDGES are dropped and flagged on overflow_o. The forest is then built by
// a sequencer that, for each of the N stored edges, runs a scan of the edge
// memory to pick the next edge in weight order (ties by arrival), a scan to
// look up the component labels of its endpoints and, when two components join,
// a relabel scan; each scan reads the edge and label memories through a single
// read port. Self-loops never survive. Kept edges come out in ascending weight,
// each word read from the result store in ST_OUT_RD and held in ST_OUT_SHOW
// until taken, the last with last_result_o; with no survivor one word with
// empty_res_o is sent. Input is not taken while a run is in progress.
module reverse_delete_spanning_forest_core import rdsf_pkg::*; #(
  parameter int unsigned MAX_EDGES   = MaxEdgesDef,
  parameter int unsigned VERTEX_BITS = VertexBitsDef,
  parameter int unsigned WEIGHT_BITS = WeightBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VERTEX_BITS-1:0] first_vertex_i,
  input  logic [VERTEX_BITS-1:0] second_vertex_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic                   last_edge_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VERTEX_BITS-1:0] out_first_vertex_o,
  output logic [VERTEX_BITS-1:0] out_second_vertex_o,
  output logic [WEIGHT_BITS-1:0] out_weight_o,
  output logic                   last_result_o,
  output logic                   empty_res_o,
  output logic                   overflow_o
);

  cmd_t cmd;
  sts_t sts;

  rdsf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_edge_i   (last_edge_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_result_o (last_result_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rdsf_datapath #(
    .MAX_EDGES   (MAX_EDGES),
    .VERTEX_BITS (VERTEX_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .first_vertex_i      (first_vertex_i),
    .second_vertex_i     (second_vertex_i),
    .weight_i            (weight_i),
    .out_first_vertex_o  (out_first_vertex_o),
    .out_second_vertex_o (out_second_vertex_o),
    .out_weight_o        (out_weight_o),
    .empty_res_o         (empty_res_o),
    .overflow_o          (overflow_o)
  );

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_result_o)
    else $error("empty word without last mark");

  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken during output");

  a_last_returns_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_result_o |=> in_ready_o && !out_valid_o)
    else $error("no return to load after last word");

  a_scan_quiet_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !sts.busy)
    else $error("scan active during output");

endmodule

### design/rdsf_datapath.sv
// ----------------------------------------------------------------------------
// rdsf_datapath
// edge store, component labels, scan engine and result list
// ----------------------------------------------------------------------------
module rdsf_datapath import rdsf_pkg::*; #(
  parameter int unsigned MAX_EDGES   = MaxEdgesDef,
  parameter int unsigned VERTEX_BITS = VertexBitsDef,
  parameter int unsigned WEIGHT_BITS = WeightBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [VERTEX_BITS-1:0] first_vertex_i,
  input  logic [VERTEX_BITS-1:0] second_vertex_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  output logic [VERTEX_BITS-1:0] out_first_vertex_o,
  output logic [VERTEX_BITS-1:0] out_second_vertex_o,
  output logic [WEIGHT_BITS-1:0] out_weight_o,
  output logic                   empty_res_o,
  output logic                   overflow_o
);

  localparam int unsigned IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned VB = VERTEX_BITS;
  localparam int unsigned WB = WEIGHT_BITS;
  localparam int unsigned EW = 2 * VB + WB;

  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic [IW-1:0] comp_mem [MAX_EDGES];
  logic [EW-1:0] res_mem  [MAX_EDGES];

  logic [EW-1:0] edge_rd_q;
  logic [IW-1:0] comp_rd_q;
  logic [EW-1:0] res_rd_q;

  logic [CW-1:0] n_q, n_d, kc_q, kc_d, rank_q, rank_d, oi_q, oi_d;
  logic          ovf_q, ovf_d;
  logic [MAX_EDGES-1:0] done_q, done_d, kept_q, kept_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          run_q, run_d, dv_q, dv_d;
  scan_e         mode_q, mode_d;
  logic [IW-1:0] didx_q, didx_d;
  logic          bf_q, bf_d, fu_q, fu_d, fv_q, fv_d;
  logic [IW-1:0] bi_q, bi_d, cu_q, cu_d, cv_q, cv_d;
  logic [VB-1:0] bu_q, bu_d, bv_q, bv_d;
  logic [WB-1:0] bw_q, bw_d;

  logic          full;
  logic [VB-1:0] rd_s, rd_e;
  logic [WB-1:0] rd_w;
  logic [IW-1:0] new_lab;
  logic          merge_wr;

  assign full     = (n_q == CW'(MAX_EDGES));
  assign rd_s     = edge_rd_q[EW-1 -: VB];
  assign rd_e     = edge_rd_q[WB +: VB];
  assign rd_w     = edge_rd_q[WB-1:0];
  assign new_lab  = fu_q ? cu_q : (fv_q ? cv_q : bi_q);
  assign merge_wr = dv_q && (mode_q == SCAN_MERGE) && done_q[didx_q] && kept_q[didx_q]
                    && (comp_rd_q == cv_q);

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      edge_mem[n_q[IW-1:0]] <= {first_vertex_i, second_vertex_i, weight_i};
    end
    edge_rd_q <= edge_mem[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep) begin
      comp_mem[bi_q] <= new_lab;
    end else if (merge_wr) begin
      comp_mem[didx_q] <= cu_q;
    end
    comp_rd_q <= comp_mem[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep) begin
      res_mem[kc_q[IW-1:0]] <= {bu_q, bv_q, bw_q};
    end
    if (cmd_i.out_rd) begin
      res_rd_q <= res_mem[oi_q[IW-1:0]];
    end
  end

  always_comb begin
    n_d    = n_q;
    ovf_d  = ovf_q;
    kc_d   = kc_q;
    rank_d = rank_q;
    oi_d   = oi_q;
    done_d = done_q;
    kept_d = kept_q;
    idx_d  = idx_q;
    run_d  = run_q;
    mode_d = mode_q;
    dv_d   = run_q;
    didx_d = idx_q[IW-1:0];
    bf_d   = bf_q;
    bi_d   = bi_q;
    bu_d   = bu_q;
    bv_d   = bv_q;
    bw_d   = bw_q;
    fu_d   = fu_q;
    fv_d   = fv_q;
    cu_d   = cu_q;
    cv_d   = cv_q;

    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        n_d = n_q + CW'(1);
      end
    end

    // scan engine
    if (run_q) begin
      idx_d = idx_q + CW'(1);
      if (idx_q == n_q - CW'(1)) begin
        run_d = 1'b0;
      end
    end
    if (cmd_i.scan_start) begin
      idx_d  = '0;
      run_d  = 1'b1;
      mode_d = cmd_i.scan_mode;
      if (cmd_i.scan_mode == SCAN_SEL) begin
        bf_d = 1'b0;
      end
      if (cmd_i.scan_mode == SCAN_FIND) begin
        fu_d = 1'b0;
        fv_d = 1'b0;
      end
    end

    if (dv_q && (mode_q == SCAN_SEL) && !done_q[didx_q]) begin
      if (!bf_q || (rd_w < bw_q)) begin
        bf_d = 1'b1;
        bi_d = didx_q;
        bu_d = rd_s;
        bv_d = rd_e;
        bw_d = rd_w;
      end
    end

    if (dv_q && (mode_q == SCAN_FIND) && done_q[didx_q] && kept_q[didx_q]) begin
      if ((rd_s == bu_q) || (rd_e == bu_q)) begin
        fu_d = 1'b1;
        cu_d = comp_rd_q;
      end
      if ((rd_s == bv_q) || (rd_e == bv_q)) begin
        fv_d = 1'b1;
        cv_d = comp_rd_q;
      end
    end

    if (cmd_i.mark) begin
      done_d[bi_q] = 1'b1;
    end
    if (cmd_i.keep) begin
      kept_d[bi_q] = 1'b1;
      kc_d         = kc_q + CW'(1);
    end
    if (cmd_i.next_rank) begin
      rank_d = rank_q + CW'(1);
    end
    if (cmd_i.out_next) begin
      oi_d = oi_q + CW'(1);
    end
    if (cmd_i.clear) begin
      n_d    = '0;
      ovf_d  = 1'b0;
      kc_d   = '0;
      rank_d = '0;
      oi_d   = '0;
      done_d = '0;
      kept_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      ovf_q  <= 1'b0;
      kc_q   <= '0;
      rank_q <= '0;
      oi_q   <= '0;
      done_q <= '0;
      kept_q <= '0;
      idx_q  <= '0;
      run_q  <= 1'b0;
      dv_q   <= 1'b0;
      mode_q <= SCAN_SEL;
      bf_q   <= 1'b0;
      fu_q   <= 1'b0;
      fv_q   <= 1'b0;
    end else begin
      n_q    <= n_d;
      ovf_q  <= ovf_d;
      kc_q   <= kc_d;
      rank_q <= rank_d;
      oi_q   <= oi_d;
      done_q <= done_d;
      kept_q <= kept_d;
      idx_q  <= idx_d;
      run_q  <= run_d;
      dv_q   <= dv_d;
      mode_q <= mode_d;
      bf_q   <= bf_d;
      fu_q   <= fu_d;
      fv_q   <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q <= didx_d;
    bi_q   <= bi_d;
    bu_q   <= bu_d;
    bv_q   <= bv_d;
    bw_q   <= bw_d;
    cu_q   <= cu_d;
    cv_q   <= cv_d;
  end

  assign sts_o.busy      = run_q || dv_q;
  assign sts_o.reject    = (bu_q == bv_q) || (fu_q && fv_q && (cu_q == cv_q));
  assign sts_o.merge     = fu_q && fv_q;
  assign sts_o.last_rank = (rank_q == n_q - CW'(1));
  assign sts_o.out_last  = (kc_q == '0) || (oi_q == kc_q - CW'(1));

  assign empty_res_o         = (kc_q == '0);
  assign overflow_o          = ovf_q;
  assign out_first_vertex_o  = empty_res_o ? '0 : res_rd_q[EW-1 -: VB];
  assign out_second_vertex_o = empty_res_o ? '0 : res_rd_q[WB +: VB];
  assign out_weight_o        = empty_res_o ? '0 : res_rd_q[WB-1:0];

endmodule

### design/rdsf_ctrl.sv
// ----------------------------------------------------------------------------
// rdsf_ctrl
// sequencer for load, edge selection, connectivity test and result output
// ----------------------------------------------------------------------------
module rdsf_ctrl import rdsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic last_edge_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic last_result_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && last_edge_i) begin
          state_d = ST_SEL_GO;
        end
      end
      ST_SEL_GO:   state_d = ST_SEL_WAIT;
      ST_SEL_WAIT: begin
        if (!sts_i.busy) begin
          state_d = ST_FIND_GO;
        end
      end
      ST_FIND_GO:   state_d = ST_FIND_WAIT;
      ST_FIND_WAIT: begin
        if (!sts_i.busy) begin
          state_d = sts_i.reject ? ST_NEXT : ST_UPD;
        end
      end
      ST_UPD:        state_d = sts_i.merge ? ST_MERGE_GO : ST_NEXT;
      ST_MERGE_GO:   state_d = ST_MERGE_WAIT;
      ST_MERGE_WAIT: begin
        if (!sts_i.busy) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT:   state_d = sts_i.last_rank ? ST_OUT_RD : ST_SEL_GO;
      ST_OUT_RD: state_d = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        if (out_ready_i) begin
          state_d = sts_i.out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.scan_mode = SCAN_SEL;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    last_result_o = sts_i.out_last;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SEL_GO: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_mode  = SCAN_SEL;
      end
      ST_FIND_GO: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_mode  = SCAN_FIND;
        cmd_o.mark       = 1'b1;
      end
      ST_UPD:      cmd_o.keep = 1'b1;
      ST_MERGE_GO: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_mode  = SCAN_MERGE;
      end
      ST_NEXT:   cmd_o.next_rank = 1'b1;
      ST_OUT_RD: cmd_o.out_rd = 1'b1;
      ST_OUT_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          cmd_o.clear    = sts_i.out_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the reverse-delete spanning forest core
// ----------------------------------------------------------------------------
// Edge lists go in as graphs of random size and content, among them a full
// store and lists that overflow it. A predictor in the bench builds the
// expected forest from each accepted list. Every result word is compared
// with the oldest expected word. Both sides idle at random in two of three
// phases, and the receiver once holds off long enough to stall the core input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rdsf_pkg::*;

  localparam int unsigned Cap   = MaxEdgesDef;
  localparam int unsigned Limit = 100000;

  typedef struct packed {
    logic [7:0]  v1;
    logic [7:0]  v2;
    logic [15:0] w;
    logic        last;
  } edge_word_t;

  typedef struct packed {
    logic [7:0]  v1;
    logic [7:0]  v2;
    logic [15:0] w;
    logic        last;
    logic        empty;
    logic        ovf;
  } forest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  first_vertex = '0;
  logic [7:0]  second_vertex = '0;
  logic [15:0] weight = '0;
  logic        last_edge = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_first_vertex;
  logic [7:0]  out_second_vertex;
  logic [15:0] out_weight;
  logic        last_result;
  logic        empty_res;
  logic        overflow;

  reverse_delete_spanning_forest_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .first_vertex_i      (first_vertex),
    .second_vertex_i     (second_vertex),
    .weight_i            (weight),
    .last_edge_i         (last_edge),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .out_first_vertex_o  (out_first_vertex),
    .out_second_vertex_o (out_second_vertex),
    .out_weight_o        (out_weight),
    .last_result_o       (last_result),
    .empty_res_o         (empty_res),
    .overflow_o          (overflow)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  edge_word_t   pending_edges[$];
  forest_word_t forest_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned graphs_done = 0;
  int unsigned edges_taken = 0;
  int unsigned words_seen = 0;
  int unsigned overflow_graphs = 0;
  int unsigned empty_graphs = 0;
  int unsigned quiet_cycles = 0;

  // predictor copy of the edge store
  logic [7:0]  st_a[Cap];
  logic [7:0]  st_b[Cap];
  logic [15:0] st_w[Cap];
  bit          st_kept[Cap];
  int unsigned st_count = 0;
  bit          st_ovf = 1'b0;

  function automatic bit joined_elsewhere(int unsigned idx);
    bit [255:0]  seen;
    logic [7:0]  frontier[$];
    logic [7:0]  v;
    logic [7:0]  other;
    seen = '0;
    if (st_a[idx] == st_b[idx]) return 1'b1;
    frontier.push_back(st_a[idx]);
    seen[st_a[idx]] = 1'b1;
    while (frontier.size() > 0) begin
      v = frontier.pop_front();
      for (int unsigned j = 0; j < st_count; j++) begin
        if (j == idx || !st_kept[j]) continue;
        if (st_a[j] == v) other = st_b[j];
        else if (st_b[j] == v) other = st_a[j];
        else continue;
        if (other == st_b[idx]) return 1'b1;
        if (!seen[other]) begin
          seen[other] = 1'b1;
          frontier.push_back(other);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void build_forest();
    logic [7:0]   a, b;
    logic [15:0]  w;
    int           j;
    int unsigned  kept_n;
    forest_word_t r;
    for (int unsigned i = 1; i < st_count; i++) begin
      a = st_a[i]; b = st_b[i]; w = st_w[i];
      j = i;
      while (j > 0 && st_w[j-1] > w) begin
        st_a[j] = st_a[j-1]; st_b[j] = st_b[j-1]; st_w[j] = st_w[j-1];
        j--;
      end
      st_a[j] = a; st_b[j] = b; st_w[j] = w;
    end
    for (int unsigned i = 0; i < st_count; i++) st_kept[i] = 1'b1;
    for (int i = int'(st_count) - 1; i >= 0; i--)
      if (joined_elsewhere(i)) st_kept[i] = 1'b0;
    kept_n = 0;
    for (int unsigned i = 0; i < st_count; i++) begin
      if (!st_kept[i]) continue;
      r = '{v1: st_a[i], v2: st_b[i], w: st_w[i], last: 1'b0, empty: 1'b0, ovf: st_ovf};
      forest_q.push_back(r);
      kept_n++;
    end
    if (kept_n == 0) begin
      forest_q.push_back('{v1: '0, v2: '0, w: '0, last: 1'b1, empty: 1'b1, ovf: st_ovf});
      empty_graphs++;
    end else begin
      forest_q[forest_q.size()-1].last = 1'b1;
    end
    if (st_ovf) overflow_graphs++;
    graphs_done++;
    st_count = 0;
    st_ovf = 1'b0;
  endfunction

  function automatic void take_edge(edge_word_t e);
    if (st_count < Cap) begin
      st_a[st_count] = e.v1;
      st_b[st_count] = e.v2;
      st_w[st_count] = e.w;
      st_count++;
    end else begin
      st_ovf = 1'b1;
    end
    edges_taken++;
    if (e.last) build_forest();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    edge_word_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        take_edge('{v1: first_vertex, v2: second_vertex, w: weight, last: last_edge});
      if (!in_valid || in_ready) begin
        if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_edges.pop_front();
          in_valid      <= 1'b1;
          first_vertex  <= nxt.v1;
          second_vertex <= nxt.v2;
          weight        <= nxt.w;
          last_edge     <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    forest_word_t got;
    forest_word_t exp_w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        got = '{v1: out_first_vertex, v2: out_second_vertex, w: out_weight,
                last: last_result, empty: empty_res, ovf: overflow};
        if (forest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          exp_w = forest_q.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_w, got);
          end
        end
      end
      if (hold_request > 0 && hold_left == 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= Limit) begin
      $display("watchdog expired with %0d words outstanding", forest_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_edge(input logic [7:0] a, input logic [7:0] b,
                          input logic [15:0] w, input bit last);
    pending_edges.push_back('{v1: a, v2: b, w: w, last: last});
  endtask

  task automatic add_graph(input int unsigned n, input bit wide);
    int unsigned vmax;
    logic [15:0] w;
    vmax = $urandom_range(1, 9);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) w = 16'($urandom);
      else w = 16'($urandom_range(6));
      if (wide)
        add_edge(8'($urandom), 8'($urandom), w, i == n - 1);
      else
        add_edge(8'($urandom_range(vmax)), 8'($urandom_range(vmax)), w, i == n - 1);
    end
  endtask

  task automatic drain();
    while (pending_edges.size() > 0 || in_valid || forest_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic random_graphs(input int unsigned edge_budget);
    int unsigned used;
    int unsigned n;
    used = 0;
    while (used < edge_budget) begin
      n = $urandom_range(1, 12);
      add_graph(n, $urandom_range(4) == 0);
      used += n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single edge at the field extremes
    add_edge(8'd0, 8'd255, 16'hFFFF, 1'b1);
    // lone self-loop gives an empty forest
    add_edge(8'd255, 8'd255, 16'd0, 1'b1);
    // triangle with equal weights, later arrival drops
    add_edge(8'd1, 8'd2, 16'd5, 1'b0);
    add_edge(8'd2, 8'd3, 16'd5, 1'b0);
    add_edge(8'd3, 8'd1, 16'd5, 1'b1);
    // parallel edges, self-loop, disjoint part, zero weight
    add_edge(8'd170, 8'd85, 16'hAAAA, 1'b0);
    add_edge(8'd85, 8'd170, 16'h5555, 1'b0);
    add_edge(8'd9, 8'd9, 16'd1, 1'b0);
    add_edge(8'd200, 8'd201, 16'd0, 1'b0);
    add_edge(8'd201, 8'd200, 16'd0, 1'b1);
    // square with heavy diagonal
    add_edge(8'd10, 8'd11, 16'd4, 1'b0);
    add_edge(8'd11, 8'd12, 16'd3, 1'b0);
    add_edge(8'd12, 8'd13, 16'd2, 1'b0);
    add_edge(8'd13, 8'd10, 16'd1, 1'b0);
    add_edge(8'd10, 8'd12, 16'hFFFE, 1'b1);

    send_idle_pct = 25;
    recv_idle_pct = 88;
    random_graphs(30);
    add_graph(Cap, 1'b0);
    drain();

    send_idle_pct = 88;
    recv_idle_pct = 25;
    random_graphs(20);
    add_graph(Cap + 1, 1'b0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 3000;
    random_graphs(10);
    add_graph(Cap + 6, 1'b1);
    random_graphs(15);
    drain();

    repeat (100) @(posedge clk_i);
    $display("%0d graphs, %0d edges, %0d forest words; %0d empty, %0d with overflow",
             graphs_done, edges_taken, words_seen, empty_graphs, overflow_graphs);
    if (mismatches == 0 && forest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, forest_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/rdsf_pkg.sv
design/rdsf_datapath.sv
design/rdsf_ctrl.sv
design/reverse_delete_spanning_forest_core.sv
bench/tb_top.sv
